@@ hdl/lppd_pkg.sv @@
// shared constants and types of the length-prefixed package deframer
package lppd_pkg;

  localparam int unsigned MAX_SIZE_BITS         = 23;
  localparam int unsigned POSITION_BITS_DEFAULT = 23;
  localparam int unsigned FIELD_BITS            = 32;
  localparam int unsigned HEADER_BYTES          = 32;
  localparam int unsigned SIZE_END              = 4;
  localparam int unsigned TYPE_OFFSET           = 16;
  localparam int unsigned TYPE_END              = 20;
  localparam logic [MAX_SIZE_BITS-1:0] DEFAULT_MAX_SIZE = MAX_SIZE_BITS'(4 * 1024 * 1024);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_PAYLOAD     = 2'd0;
  localparam kind_t KIND_HEADER_ONLY = 2'd1;
  localparam kind_t KIND_SIZE_ERROR  = 2'd2;

  typedef struct packed {
    logic [FIELD_BITS-1:0] package_type;
    logic [FIELD_BITS-1:0] package_size;
    logic [7:0]            payload_byte;
    logic                  last_of_package;
    kind_t                 result_kind;
  } result_t;

endpackage

@@ hdl/length_prefixed_package_deframer_unit.sv @@
// length-prefixed package deframer: header parse, size check, payload tagging
//
// channel   dir  transfer            payload
// s_axis    in   one stream byte     tdata = stream_byte
// m_axis    out  one result          tdata/tuser/tlast
// cfg       in   limit write         cfg_data = max_package_size
//
// one byte per cycle while s_axis_tready is high; each byte updates the position
// counter and header shift registers, and a byte that yields a result puts it in
// the output register, or while m_axis is stalled in a skid register that keeps
// s_axis_tready high for one extra result
// synchronous reset restores the default size limit and clears the parse state and output valids
// after a size error no further results appear until reset
module length_prefixed_package_deframer_unit #(
  parameter int unsigned POSITION_BITS = lppd_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // stream_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [71:0]                         m_axis_tdata,   // payload_byte, package_size, package_type
  output logic [1:0]                          m_axis_tuser,   // result_kind
  output logic                                m_axis_tlast,   // last_of_package
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lppd_pkg::MAX_SIZE_BITS-1:0]  cfg_data        // max_package_size
);

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned FB = lppd_pkg::FIELD_BITS;
  localparam logic [PB-1:0] POS_HDR      = PB'(lppd_pkg::HEADER_BYTES);
  localparam logic [PB-1:0] POS_HDR_LAST = PB'(lppd_pkg::HEADER_BYTES - 1);
  localparam logic [PB-1:0] POS_SIZE_END = PB'(lppd_pkg::SIZE_END);
  localparam logic [PB-1:0] POS_TYPE     = PB'(lppd_pkg::TYPE_OFFSET);
  localparam logic [PB-1:0] POS_TYPE_END = PB'(lppd_pkg::TYPE_END);
  localparam logic [FB:0]   POS_CAP      = (FB+1)'(1) << PB;
  localparam logic [FB:0]   HDR_SIZE     = (FB+1)'(lppd_pkg::HEADER_BYTES);

  logic [lppd_pkg::MAX_SIZE_BITS-1:0] max_package_size;
  logic [PB-1:0]                      byte_position, byte_position_next;
  logic [FB-1:0]                      size_field, size_field_next;
  logic [FB-1:0]                      type_field, type_field_next;
  logic                               failed_flag, failed_flag_next;

  lppd_pkg::result_t out_res, skid_res, res;
  logic              out_valid, skid_valid;
  logic              have_result, s_fire, produce, out_free;

  logic [FB-1:0] size_upd, type_upd;
  logic [FB:0]   limit, size_ext, pos_inc;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign produce       = s_fire && have_result;
  assign out_free      = !out_valid || m_axis_tready;

  assign limit    = ((FB+1)'(max_package_size) < POS_CAP) ? (FB+1)'(max_package_size) : POS_CAP;
  assign pos_inc  = (FB+1)'(byte_position) + (FB+1)'(1);

  // per-byte parse step
  always_comb begin
    size_upd = size_field;
    type_upd = type_field;
    if (byte_position < POS_SIZE_END) begin
      size_upd = {size_field[FB-9:0], s_axis_tdata};
    end else if (byte_position >= POS_TYPE && byte_position < POS_TYPE_END) begin
      type_upd = {type_field[FB-9:0], s_axis_tdata};
    end
    size_ext = {1'b0, size_upd};

    byte_position_next = byte_position;
    size_field_next    = size_field;
    type_field_next    = type_field;
    failed_flag_next   = failed_flag;
    have_result        = 1'b0;
    res.result_kind     = lppd_pkg::KIND_PAYLOAD;
    res.payload_byte    = 8'd0;
    res.last_of_package = 1'b0;
    res.package_size    = size_upd;
    res.package_type    = type_upd;

    if (!failed_flag) begin
      if (byte_position < POS_HDR) begin
        size_field_next = size_upd;
        type_field_next = type_upd;
        if (byte_position != POS_HDR_LAST) begin
          byte_position_next = PB'(pos_inc);
        end else if (size_ext < HDR_SIZE || size_ext > limit) begin
          failed_flag_next   = 1'b1;
          byte_position_next = '0;
          have_result        = 1'b1;
          res.result_kind    = lppd_pkg::KIND_SIZE_ERROR;
        end else if (size_ext == HDR_SIZE) begin
          byte_position_next  = '0;
          have_result         = 1'b1;
          res.result_kind     = lppd_pkg::KIND_HEADER_ONLY;
          res.last_of_package = 1'b1;
        end else begin
          byte_position_next = POS_HDR;
        end
      end else begin
        have_result      = 1'b1;
        res.payload_byte = s_axis_tdata;
        if (pos_inc >= {1'b0, size_field}) begin
          byte_position_next  = '0;
          res.last_of_package = 1'b1;
          size_field_next     = '0;
          type_field_next     = '0;
        end else begin
          byte_position_next = PB'(pos_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_package_size <= lppd_pkg::DEFAULT_MAX_SIZE;
      byte_position    <= '0;
      size_field       <= '0;
      type_field       <= '0;
      failed_flag      <= 1'b0;
      out_valid        <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_package_size <= cfg_data;
      end
      if (s_fire) begin
        byte_position <= byte_position_next;
        size_field    <= size_field_next;
        type_field    <= type_field_next;
        failed_flag   <= failed_flag_next;
      end
      // output register with skid stage
      if (out_free) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          out_valid  <= 1'b1;
          skid_valid <= produce;
          skid_res   <= res;
        end else begin
          out_valid <= produce;
          out_res   <= res;
        end
      end else if (produce) begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.package_type, out_res.package_size, out_res.payload_byte};
  assign m_axis_tuser  = out_res.result_kind;
  assign m_axis_tlast  = out_res.last_of_package;

endmodule

@@ test/length_prefixed_package_deframer_unit_tb.sv @@
// testbench of the length-prefixed package deframer: random packages, predicted results, limits
`timescale 1ns / 100ps

module length_prefixed_package_deframer_unit_tb;

  localparam int unsigned POS_BITS = lppd_pkg::POSITION_BITS_DEFAULT;
  localparam logic [lppd_pkg::MAX_SIZE_BITS-1:0] TOP_LIMIT = {lppd_pkg::MAX_SIZE_BITS{1'b1}};
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_BYTES = 30;

  typedef enum {FAULT_SMALL_SIZE, FAULT_OVER_LIMIT, FAULT_LOW_LIMIT} size_fault_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lppd_pkg::MAX_SIZE_BITS-1:0] cfg_data = '0;

  length_prefixed_package_deframer_unit DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // deframer state as predicted
  logic [POS_BITS-1:0] byte_pos = '0;
  logic [lppd_pkg::FIELD_BITS-1:0] size_acc = '0;
  logic [lppd_pkg::FIELD_BITS-1:0] type_acc = '0;
  logic size_failed = 1'b0;
  logic [lppd_pkg::MAX_SIZE_BITS-1:0] size_limit = lppd_pkg::DEFAULT_MAX_SIZE;

  logic [7:0] stream_q[$];
  lppd_pkg::result_t expected_results[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int stall_cycles = 0;
  int packages_queued = 0;
  int header_only_queued = 0;
  int limit_writes = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void push_result(input lppd_pkg::kind_t kind, input logic [7:0] data,
                                      input logic last);
    lppd_pkg::result_t r;
    r.result_kind = kind;
    r.payload_byte = data;
    r.last_of_package = last;
    r.package_size = size_acc;
    r.package_type = type_acc;
    expected_results = {expected_results, r};
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    if (size_failed) return;
    if (byte_pos < lppd_pkg::HEADER_BYTES) begin
      if (byte_pos < lppd_pkg::SIZE_END) size_acc = {size_acc[23:0], b};
      else if (byte_pos >= lppd_pkg::TYPE_OFFSET && byte_pos < lppd_pkg::TYPE_END)
        type_acc = {type_acc[23:0], b};
      if (byte_pos + 1 < lppd_pkg::HEADER_BYTES) begin
        byte_pos = byte_pos + 1'b1;
        return;
      end
      if (size_acc < lppd_pkg::HEADER_BYTES || size_acc > size_limit) begin
        size_failed = 1'b1;
        byte_pos = '0;
        push_result(lppd_pkg::KIND_SIZE_ERROR, 8'h00, 1'b0);
      end else if (size_acc == lppd_pkg::HEADER_BYTES) begin
        byte_pos = '0;
        push_result(lppd_pkg::KIND_HEADER_ONLY, 8'h00, 1'b1);
      end else begin
        byte_pos = lppd_pkg::HEADER_BYTES;
      end
      return;
    end
    if (byte_pos + 1 >= size_acc) begin
      byte_pos = '0;
      push_result(lppd_pkg::KIND_PAYLOAD, b, 1'b1);
      size_acc = '0;
      type_acc = '0;
    end else begin
      byte_pos = byte_pos + 1'b1;
      push_result(lppd_pkg::KIND_PAYLOAD, b, 1'b0);
    end
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (stream_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= stream_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // result check, prediction and watchdog
  lppd_pkg::result_t exp_r;
  lppd_pkg::result_t got_r;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_r.result_kind = m_axis_tuser;
        got_r.payload_byte = m_axis_tdata[7:0];
        got_r.last_of_package = m_axis_tlast;
        got_r.package_size = m_axis_tdata[39:8];
        got_r.package_type = m_axis_tdata[71:40];
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result at %0t: kind %0d byte %h last %b size %h type %h",
                     $time, got_r.result_kind, got_r.payload_byte, got_r.last_of_package,
                     got_r.package_size, got_r.package_type);
        end else begin
          exp_r = expected_results.pop_front();
          results_checked++;
          if (got_r.result_kind !== exp_r.result_kind ||
              got_r.payload_byte !== exp_r.payload_byte ||
              got_r.last_of_package !== exp_r.last_of_package ||
              got_r.package_size !== exp_r.package_size ||
              got_r.package_type !== exp_r.package_type) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch at %0t: expected kind %0d byte %h last %b size %h type %h,",
                        " got kind %0d byte %h last %b size %h type %h"},
                       $time, exp_r.result_kind, exp_r.payload_byte, exp_r.last_of_package,
                       exp_r.package_size, exp_r.package_type, got_r.result_kind,
                       got_r.payload_byte, got_r.last_of_package, got_r.package_size,
                       got_r.package_type);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("no transfer for %0d cycles", STALL_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  function automatic void queue_package(input logic [31:0] size, input logic [31:0] ptype,
                                        input int unsigned body_len);
    for (int i = 0; i < 4; i++) stream_q = {stream_q, size[31 - 8 * i -: 8]};
    for (int i = lppd_pkg::SIZE_END; i < lppd_pkg::TYPE_OFFSET; i++)
      stream_q = {stream_q, 8'($urandom)};
    for (int i = 0; i < 4; i++) stream_q = {stream_q, ptype[31 - 8 * i -: 8]};
    for (int i = lppd_pkg::TYPE_END; i < lppd_pkg::HEADER_BYTES; i++)
      stream_q = {stream_q, 8'($urandom)};
    for (int i = 0; i < body_len; i++) stream_q = {stream_q, 8'($urandom)};
    packages_queued++;
    if (size == lppd_pkg::HEADER_BYTES) header_only_queued++;
  endfunction

  function automatic void queue_good_package(input logic [31:0] size);
    queue_package(size, $urandom, size - lppd_pkg::HEADER_BYTES);
  endfunction

  function automatic int unsigned pick_size(input logic [lppd_pkg::MAX_SIZE_BITS-1:0] lim);
    int unsigned span;
    int unsigned len;
    int roll;
    span = lim - lppd_pkg::HEADER_BYTES;
    roll = $urandom_range(0, 99);
    if (roll < 8 && span <= 200) return lim;
    if (roll < 70) len = $urandom_range(0, 6);
    else if (roll < 95) len = $urandom_range(7, 40);
    else len = $urandom_range(41, 200);
    if (len > span) len = span;
    return lppd_pkg::HEADER_BYTES + len;
  endfunction

  task automatic wait_drained();
    while (stream_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [lppd_pkg::MAX_SIZE_BITS-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    size_limit = value;
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  logic [lppd_pkg::MAX_SIZE_BITS-1:0] phase_limits[6];
  size_fault_t fault;
  int unsigned phase_start;
  int unsigned noise_len;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 28;
    rx_idle_pct = 62;

    // directed: header-only, shortest payloads, type extremes, a longer body
    queue_package(lppd_pkg::HEADER_BYTES, 32'hFFFF_FFFF, 0);
    queue_package(lppd_pkg::HEADER_BYTES + 1, 32'h0000_0000, 0);
    stream_q = {stream_q, 8'h00};
    queue_package(lppd_pkg::HEADER_BYTES + 2, 32'h8000_0001, 0);
    stream_q = {stream_q, 8'hFF};
    stream_q = {stream_q, 8'h5A};
    queue_package(lppd_pkg::HEADER_BYTES, 32'h0000_0000, 0);
    queue_good_package(lppd_pkg::HEADER_BYTES + 24);
    wait_drained();

    phase_limits[0] = lppd_pkg::HEADER_BYTES;
    phase_limits[1] = TOP_LIMIT;
    phase_limits[2] = $urandom_range(lppd_pkg::HEADER_BYTES + 1, 120);
    phase_limits[3] = lppd_pkg::DEFAULT_MAX_SIZE;
    phase_limits[4] = $urandom_range(lppd_pkg::HEADER_BYTES + 1, TOP_LIMIT);
    phase_limits[5] = $urandom_range(40, 300);

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        tx_idle_pct = 62;
        rx_idle_pct = 28;
      end else if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_limit(phase_limits[p]);
      phase_start = stream_q.size();
      while (stream_q.size() - phase_start < PHASE_BYTES)
        queue_good_package(pick_size(size_limit));
      wait_drained();
    end

    // sticky size error: one header is rejected, everything after it is dropped
    fault = size_fault_t'($urandom_range(0, 2));
    case (fault)
      FAULT_SMALL_SIZE: begin
        queue_good_package(pick_size(size_limit));
        queue_package($urandom_range(0, lppd_pkg::HEADER_BYTES - 1), $urandom, 0);
      end
      FAULT_OVER_LIMIT: begin
        if ($urandom_range(0, 1) == 0)
          queue_package(32'hFFFF_FFFF, $urandom, 0);
        else
          queue_package(size_limit + 1 + $urandom_range(0, 500), $urandom, 0);
      end
      FAULT_LOW_LIMIT: begin
        write_limit($urandom_range(0, 3) == 0 ? '0 :
                    $urandom_range(1, lppd_pkg::HEADER_BYTES - 1));
        queue_package(pick_size(TOP_LIMIT), $urandom, 0);
      end
      default: ;
    endcase
    noise_len = $urandom_range(20, 60);
    queue_package(lppd_pkg::HEADER_BYTES + 8, $urandom, 8);
    for (int i = 0; i < noise_len; i++) stream_q = {stream_q, 8'($urandom)};
    wait_drained();
    repeat (3 * DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d packages (%0d header-only) over %0d limit writes, %0d results checked",
             packages_queued, header_only_queued, limit_writes, results_checked);
    $display("ended on a sticky size error (%s) with %0d trailing bytes dropped",
             fault.name(), noise_len + 40);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lppd_pkg.sv
hdl/length_prefixed_package_deframer_unit.sv
test/length_prefixed_package_deframer_unit_tb.sv
